FILE: rtl/core/postfix_expression_evaluator_unit_macros.svh
// Assertion macros used by the checker file of the postfix evaluator.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

// Next-cycle implication, switched off while reset is asserted.
`define PFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define PFX_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/pfx_pkg.sv
// Package of the postfix evaluator: payload structs, symbol codes and classes.
// Used by every module of the block but pfx_ram; depends on nothing.
package pfx_pkg;

  localparam int WORD_W = 32;
  localparam int SYM_W  = 8;

  localparam logic [SYM_W-1:0] SYM_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] SYM_NINE = 8'h39;
  localparam logic [SYM_W-1:0] SYM_ADD  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'h2F;

  localparam logic signed [WORD_W-1:0] WORD_EMPTY = '1;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_ADD,
    CLS_SUB,
    CLS_MUL,
    CLS_DIV,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     underflow;
    logic                     overflow;
    logic                     divide_by_zero;
  } out_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] num;
    logic signed [WORD_W-1:0] den;
  } div_req_t;

endpackage

FILE: rtl/core/postfix_expression_evaluator_unit.sv
// Top level of the postfix (RPN) expression evaluator.
// Depends on pfx_pkg, pfx_front and pfx_back (which holds pfx_ram and pfx_div).
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+----------------------------------------
//   in_     | input     | in_valid/in_stall | pfx_pkg::in_t  {symbol, last_symbol}
//   out_    | output    | out_valid/out_stall | pfx_pkg::out_t {value, flags x3}
//
// A digit is pushed straight from idle; any other symbol pops two operands, and
// + - * / push the result. A division waits on the one-bit-per-cycle divider.
// A symbol marked last adds the final pop through the stack RAM.
// Reset is synchronous and active low; it empties the stack and the queue and
// clears the flags and the output valid. A stalled result waits in its register
// while the two-entry front queue keeps taking beats until it is full.
module postfix_expression_evaluator_unit #(
  parameter int STACK_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pfx_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pfx_pkg::out_t out_data
);

  // Classified commands flow from the front queue to the stack sequencer.
  pfx_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_take;

  // The front end decodes each beat's symbol into a command class so that
  // the back end never looks at raw ASCII codes.
  pfx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  // The back end owns the stack RAM, the sticky flags, the divider and the
  // result register; it takes one command at a time.
  pfx_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/pfx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pfx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/pfx_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on pfx_pkg for the word width and the request struct.
module pfx_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  pfx_pkg::div_req_t                req,
  output logic                             done,
  output logic signed [pfx_pkg::WORD_W-1:0] quo
);

  localparam int W = pfx_pkg::WORD_W;
  localparam int SW = $clog2(W + 1);

  logic          run_r;
  logic          done_r;
  logic [SW-1:0] steps_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic [W-1:0]  den_r;
  logic          neg_r;

  logic [W-1:0]  num_mag;
  logic [W-1:0]  den_mag;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign num_mag = req.num[W-1] ? (~req.num + W'(1)) : req.num;
  assign den_mag = req.den[W-1] ? (~req.den + W'(1)) : req.den;
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      steps_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r   <= 1'b1;
        steps_r <= SW'(W);
      end else if (run_r) begin
        steps_r <= steps_r - SW'(1);
        if (steps_r == SW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= num_mag;
      den_r <= den_mag;
      neg_r <= req.num[W-1] ^ req.den[W-1];
    end else if (run_r) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? (~quo_r + W'(1)) : quo_r;

endmodule

FILE: rtl/core/pfx_front.sv
// Front end: accepts input beats, classifies each symbol and queues commands.
// Depends on pfx_pkg for the payload and command types.
module pfx_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pfx_pkg::in_t  in_data,
  output logic          cmd_valid,
  input  logic          cmd_take,
  output pfx_pkg::cmd_t cmd
);

  pfx_pkg::cmd_t q_r [2];
  logic [1:0]    fill_r;
  logic          wp_r;
  logic          rp_r;
  pfx_pkg::cmd_t cls_cmd;
  logic          push;
  logic          pop;

  always_comb begin
    cls_cmd.digit = 4'(in_data.symbol - pfx_pkg::SYM_ZERO);
    cls_cmd.last  = in_data.last_symbol;
    unique case (in_data.symbol) inside
      [pfx_pkg::SYM_ZERO:pfx_pkg::SYM_NINE]: cls_cmd.cls = pfx_pkg::CLS_DIGIT;
      pfx_pkg::SYM_ADD: cls_cmd.cls = pfx_pkg::CLS_ADD;
      pfx_pkg::SYM_SUB: cls_cmd.cls = pfx_pkg::CLS_SUB;
      pfx_pkg::SYM_MUL: cls_cmd.cls = pfx_pkg::CLS_MUL;
      pfx_pkg::SYM_DIV: cls_cmd.cls = pfx_pkg::CLS_DIV;
      default:          cls_cmd.cls = pfx_pkg::CLS_OTHER;
    endcase
  end

  assign in_stall  = (fill_r == 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_valid && cmd_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls_cmd;
    end
  end

endmodule

FILE: rtl/core/pfx_back.sv
// Back end: stack sequencer, ALU, divider and result register.
// Depends on pfx_pkg, pfx_ram and pfx_div.
module pfx_back #(
  parameter int STACK_DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_take,
  input  pfx_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output pfx_pkg::out_t out_data
);

  localparam int W  = pfx_pkg::WORD_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_POPA = 10'b0000000010,
    ST_POPB = 10'b0000000100,
    ST_CAPB = 10'b0000001000,
    ST_EXEC = 10'b0000010000,
    ST_DIVW = 10'b0000100000,
    ST_PUSH = 10'b0001000000,
    ST_FPOP = 10'b0010000000,
    ST_FCAP = 10'b0100000000,
    ST_EMIT = 10'b1000000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               unf_r, unf_nxt;
  logic               ovf_r, ovf_nxt;
  logic               dz_r, dz_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  pfx_pkg::cmd_t      cmd_r, cmd_nxt;
  logic signed [W-1:0] opa_r, opa_nxt;
  logic signed [W-1:0] opb_r, opb_nxt;
  logic signed [W-1:0] res_r, res_nxt;
  pfx_pkg::out_t      out_r, out_nxt;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [W-1:0]       wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [W-1:0]       rdata;
  logic [CW-1:0]      cnt_m1;
  logic               full;
  logic               empty;
  pfx_pkg::div_req_t  div_req;
  logic               div_done;
  logic signed [W-1:0] div_quo;

  pfx_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  pfx_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cnt_m1 = cnt_r - CW'(1);
  assign full   = (cnt_r == CW'(STACK_DEPTH));
  assign empty  = (cnt_r == CW'(0));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    unf_nxt       = unf_r;
    ovf_nxt       = ovf_r;
    dz_nxt        = dz_r;
    pend_nxt      = pend_r;
    cmd_nxt       = cmd_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    we            = 1'b0;
    waddr         = cnt_r[AW-1:0];
    wdata         = res_r;
    re            = 1'b0;
    raddr         = cnt_m1[AW-1:0];
    cmd_take      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = opb_r;
    div_req.den   = opa_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          cmd_nxt  = cmd;
          if (cmd.cls == pfx_pkg::CLS_DIGIT) begin
            if (full) begin
              ovf_nxt = 1'b1;
            end else begin
              we      = 1'b1;
              wdata   = W'(cmd.digit);
              cnt_nxt = cnt_r + CW'(1);
            end
            state_nxt = cmd.last ? ST_FPOP : ST_IDLE;
          end else begin
            state_nxt = ST_POPA;
          end
        end
      end
      ST_POPA: begin
        // First pop: the top word arrives from the RAM next cycle.
        if (empty) begin
          unf_nxt  = 1'b1;
          opa_nxt  = pfx_pkg::WORD_EMPTY;
          pend_nxt = 1'b0;
        end else begin
          re       = 1'b1;
          cnt_nxt  = cnt_m1;
          pend_nxt = 1'b1;
        end
        state_nxt = ST_POPB;
      end
      ST_POPB: begin
        if (pend_r) begin
          opa_nxt = rdata;
        end
        if (empty) begin
          unf_nxt  = 1'b1;
          opb_nxt  = pfx_pkg::WORD_EMPTY;
          pend_nxt = 1'b0;
        end else begin
          re       = 1'b1;
          cnt_nxt  = cnt_m1;
          pend_nxt = 1'b1;
        end
        state_nxt = ST_CAPB;
      end
      ST_CAPB: begin
        if (pend_r) begin
          opb_nxt = rdata;
        end
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (cmd_r.cls)
          pfx_pkg::CLS_ADD: begin
            res_nxt   = opb_r + opa_r;
            state_nxt = ST_PUSH;
          end
          pfx_pkg::CLS_SUB: begin
            res_nxt   = opb_r - opa_r;
            state_nxt = ST_PUSH;
          end
          pfx_pkg::CLS_MUL: begin
            res_nxt   = opb_r * opa_r;
            state_nxt = ST_PUSH;
          end
          pfx_pkg::CLS_DIV: begin
            if (opa_r == W'(0)) begin
              dz_nxt    = 1'b1;
              res_nxt   = '0;
              state_nxt = ST_PUSH;
            end else begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIVW;
            end
          end
          default: begin
            state_nxt = cmd_r.last ? ST_FPOP : ST_IDLE;
          end
        endcase
      end
      ST_DIVW: begin
        if (div_done) begin
          res_nxt   = div_quo;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          we      = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = cmd_r.last ? ST_FPOP : ST_IDLE;
      end
      ST_FPOP: begin
        if (empty) begin
          unf_nxt  = 1'b1;
          opa_nxt  = pfx_pkg::WORD_EMPTY;
          pend_nxt = 1'b0;
        end else begin
          re       = 1'b1;
          cnt_nxt  = cnt_m1;
          pend_nxt = 1'b1;
        end
        state_nxt = ST_FCAP;
      end
      ST_FCAP: begin
        if (pend_r) begin
          opa_nxt = rdata;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // The result register may still hold an unread beat; wait for it.
        if (!out_valid_r || !out_stall) begin
          out_nxt.value          = opa_r;
          out_nxt.underflow      = unf_r;
          out_nxt.overflow       = ovf_r;
          out_nxt.divide_by_zero = dz_r;
          out_valid_nxt          = 1'b1;
          cnt_nxt                = '0;
          unf_nxt                = 1'b0;
          ovf_nxt                = 1'b0;
          dz_nxt                 = 1'b0;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      unf_r       <= 1'b0;
      ovf_r       <= 1'b0;
      dz_r        <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      unf_r       <= unf_nxt;
      ovf_r       <= ovf_nxt;
      dz_r        <= dz_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    opa_r <= opa_nxt;
    opb_r <= opb_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/pfx_checker.sv
// Port-level checker for the postfix evaluator, bound to the top level.
// Depends on pfx_pkg and the assertion macro header.
`include "postfix_expression_evaluator_unit_macros.svh"

module pfx_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input pfx_pkg::out_t out_data
);

  `PFX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result beat dropped under stall")
  `PFX_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "result beat changed under stall")
  `PFX_ASSERT_NEXT_ALWAYS(a_rst_out, clk, !rst_n, !out_valid, "result valid after reset")
  `PFX_ASSERT_NEXT_ALWAYS(a_rst_in, clk, !rst_n, !in_stall, "input stalled after reset")

endmodule

bind postfix_expression_evaluator_unit pfx_checker u_pfx_checker (.*);
